### sv/cstp_pkg.sv
// ---------------------------------------------------------------------------
// cstp_pkg: shared types and constants of the call stack profiler
// Field widths, command and status codes, parameter defaults and totals access strobes.
// ---------------------------------------------------------------------------
`default_nettype none

package cstp_pkg;

    localparam int CMD_W    = 2;
    localparam int FID_W    = 6;
    localparam int TS_W     = 32;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 2;

    localparam int NUM_FUNCS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TIME_WIDTH_DEF  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Access strobes from the sequencer to the totals memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_tot_cmd;

endpackage

`default_nettype wire

### sv/cstp_if.sv
// ---------------------------------------------------------------------------
// cstp_if: event and result channels of the call stack profiler
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface cstp_evt_if;
    import cstp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [FID_W-1:0] func_id;
    logic [TS_W-1:0]  timestamp;

    modport source (output valid, output cmd, output func_id, output timestamp,
                    input ready);
    modport sink   (input valid, input cmd, input func_id, input timestamp,
                    output ready);
endinterface

interface cstp_res_if;
    import cstp_pkg::*;

    logic                valid;
    logic                ready;
    logic [FID_W-1:0]    func_id_out;
    logic [TOTAL_W-1:0]  total_time;
    logic                updated;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output func_id_out, output total_time,
                    output updated, output status, input ready);
    modport sink   (input valid, input func_id_out, input total_time,
                    input updated, input status, output ready);
endinterface

`default_nettype wire

### sv/cstp_totals.sv
// ---------------------------------------------------------------------------
// cstp_totals: per-function exclusive time memory
// One write port and one registered read port. After reset a clearing pass
// writes zero to every entry, one per cycle, while o_clr_busy is high.
// ---------------------------------------------------------------------------
`default_nettype none

module cstp_totals #(
    parameter int NUM_FUNCS  = cstp_pkg::NUM_FUNCS_DEF,
    parameter int TIME_WIDTH = cstp_pkg::TIME_WIDTH_DEF,
    parameter int FW         = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cstp_pkg::t_tot_cmd i_cmd,
    input  wire logic [FW-1:0]     i_rd_addr,
    input  wire logic [FW-1:0]     i_wr_addr,
    input  wire logic [TIME_WIDTH-1:0] i_wr_data,
    output logic [TIME_WIDTH-1:0]  o_rd_data,
    output logic                   o_clr_busy
);
    import cstp_pkg::*;

    logic [TIME_WIDTH-1:0] mem [NUM_FUNCS];
    logic [TIME_WIDTH-1:0] r_rd_q;
    logic                  r_clr_busy;
    logic [FW-1:0]         r_clr_addr;
    logic                  n_clr_busy;
    logic [FW-1:0]         n_clr_addr;

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + FW'(1);
            if (r_clr_addr == FW'(NUM_FUNCS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled item keeps its operand.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_q;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

### sv/call_stack_exclusive_time_profiler.sv
// ---------------------------------------------------------------------------
// call_stack_exclusive_time_profiler: exclusive run time per function
// Tracks a call stack from start and end events and accumulates saturating
// per-function exclusive times; a read command returns one total.
// ---------------------------------------------------------------------------
//  Channel  Dir  Fields                                      Transfer
//  i_evt    in   cmd, func_id, timestamp                     valid & ready
//  o_res    out  func_id_out, total_time, updated, status    valid & ready
//
//  When an event is taken it reads the totals memory and the stack entry
//  below the top; in S_EXEC it then adds, saturates and writes back.
//  The top stack entry lives in registers; the rest sits in the stack memory.
//  After reset the totals memory is cleared entry by entry; events are
//  held off during that pass and in the cycle after it.
//  An event is taken while a previous result still waits; its write-back
//  stalls until the result register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module call_stack_exclusive_time_profiler #(
    parameter int NUM_FUNCS   = cstp_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
    parameter int TIME_WIDTH  = cstp_pkg::TIME_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cstp_evt_if.sink   i_evt,
    cstp_res_if.source o_res
);
    import cstp_pkg::*;

    localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int TW = TIME_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // Control state
    t_state           r_state, n_state;
    logic [LW-1:0]    r_level, n_level;
    logic             r_out_valid, n_out_valid;

    // Stack top and captured event
    logic [FID_W-1:0] r_top_fid, n_top_fid;
    logic [TW-1:0]    r_top_time, n_top_time;
    t_cmd             r_cmd;
    logic [FID_W-1:0] r_fid;
    logic [TW-1:0]    r_ts;
    logic [TW-1:0]    r_ts_inc;
    logic [TW-1:0]    r_delta;
    logic [FID_W-1:0] r_tgt_fid;
    logic             r_tgt_ok;

    // Result register
    logic [FID_W-1:0]   r_out_fid, n_out_fid;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_upd, n_out_upd;
    t_status            r_out_status, n_out_status;

    // Stack memory
    logic [FID_W+TW-1:0] stk_mem [STACK_DEPTH];
    logic [FID_W+TW-1:0] r_stk_q;
    logic                stk_wr;

    // Totals memory access
    t_tot_cmd        tot_cmd;
    logic [FW-1:0]   tot_rd_addr;
    logic [FW-1:0]   tot_wr_addr;
    logic [TW-1:0]   tot_rd_data;
    logic            clr_busy;

    // Accept-side arithmetic
    logic            accept;
    logic            commit;
    t_cmd            in_cmd;
    logic [TW+TS_W-1:0]  ts_ext;
    logic [TW-1:0]   ts_in;
    logic [TW:0]     diff;
    logic [TW-1:0]   start_delta;
    logic [TW-1:0]   end_delta;
    logic [FID_W-1:0] tgt_fid;
    logic [FW+FID_W-1:0] tgt_ext;
    logic [FW+FID_W-1:0] top_ext;
    logic [LW-1:0]   lvl_m1;
    logic [LW-1:0]   lvl_m2;

    // Commit-side arithmetic
    logic [TW:0]     sum;
    logic [TW-1:0]   sat_sum;
    logic [TOTAL_W+TW-1:0] sat_ext;
    logic [TOTAL_W+TW-1:0] rd_ext;

    assign accept = i_evt.valid && i_evt.ready;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);
    assign in_cmd = t_cmd'(i_evt.cmd);

    assign ts_ext = {{TW{1'b0}}, i_evt.timestamp};
    assign ts_in  = ts_ext[TW-1:0];
    assign diff   = {1'b0, ts_in} - {1'b0, r_top_time};

    // Time running backwards credits nothing; an end credits inclusively.
    assign start_delta = diff[TW] ? '0 : diff[TW-1:0];
    assign end_delta   = diff[TW] ? '0 :
                         (&diff[TW-1:0]) ? diff[TW-1:0] : diff[TW-1:0] + TW'(1);

    assign tgt_fid = (in_cmd == CMD_READ) ? i_evt.func_id : r_top_fid;
    assign tgt_ext = {{FW{1'b0}}, tgt_fid};
    assign top_ext = {{FW{1'b0}}, r_top_fid};
    assign lvl_m1  = r_level - LW'(1);
    assign lvl_m2  = r_level - LW'(2);

    assign tot_rd_addr = tgt_ext[FW-1:0];
    assign tot_wr_addr = top_ext[FW-1:0];

    assign sum     = {1'b0, tot_rd_data} + {1'b0, r_delta};
    assign sat_sum = sum[TW] ? '1 : sum[TW-1:0];
    assign sat_ext = {{TOTAL_W{1'b0}}, sat_sum};
    assign rd_ext  = {{TOTAL_W{1'b0}}, tot_rd_data};

    cstp_totals #(
        .NUM_FUNCS  (NUM_FUNCS),
        .TIME_WIDTH (TIME_WIDTH),
        .FW         (FW)
    ) u_totals (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tot_cmd),
        .i_rd_addr  (tot_rd_addr),
        .i_wr_addr  (tot_wr_addr),
        .i_wr_data  (sat_sum),
        .o_rd_data  (tot_rd_data),
        .o_clr_busy (clr_busy)
    );

    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_out_valid  = r_out_valid;
        n_top_fid    = r_top_fid;
        n_top_time   = r_top_time;
        n_out_fid    = r_out_fid;
        n_out_total  = r_out_total;
        n_out_upd    = r_out_upd;
        n_out_status = r_out_status;
        tot_cmd.rd   = accept;
        tot_cmd.wr   = 1'b0;
        stk_wr       = 1'b0;

        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                if (!clr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_fid    = '0;
                    n_out_total  = '0;
                    n_out_upd    = 1'b0;
                    n_out_status = ST_OK;
                    case (r_cmd)
                        CMD_START: begin
                            if (r_level >= LW'(STACK_DEPTH)) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                if (r_level != '0) begin
                                    // The running caller is credited and saved.
                                    stk_wr = 1'b1;
                                    if (r_tgt_ok) begin
                                        tot_cmd.wr  = 1'b1;
                                        n_out_fid   = r_tgt_fid;
                                        n_out_total = sat_ext[TOTAL_W-1:0];
                                        n_out_upd   = 1'b1;
                                    end
                                end
                                n_top_fid  = r_fid;
                                n_top_time = r_ts;
                                n_level    = r_level + LW'(1);
                            end
                        end
                        CMD_END: begin
                            if (r_level == '0) begin
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                if (r_tgt_ok) begin
                                    tot_cmd.wr  = 1'b1;
                                    n_out_fid   = r_tgt_fid;
                                    n_out_total = sat_ext[TOTAL_W-1:0];
                                    n_out_upd   = 1'b1;
                                end
                                n_level = lvl_m1;
                                if (r_level > LW'(1)) begin
                                    n_top_fid  = r_stk_q[FID_W+TW-1:TW];
                                    n_top_time = r_ts_inc;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (r_tgt_ok) begin
                                n_out_fid   = r_tgt_fid;
                                n_out_total = rd_ext[TOTAL_W-1:0];
                                n_out_upd   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_fid    <= n_top_fid;
        r_top_time   <= n_top_time;
        r_out_fid    <= n_out_fid;
        r_out_total  <= n_out_total;
        r_out_upd    <= n_out_upd;
        r_out_status <= n_out_status;
        if (accept) begin
            r_cmd     <= in_cmd;
            r_fid     <= i_evt.func_id;
            r_ts      <= ts_in;
            r_ts_inc  <= (&ts_in) ? ts_in : ts_in + TW'(1);
            r_delta   <= (in_cmd == CMD_END) ? end_delta : start_delta;
            r_tgt_fid <= tgt_fid;
            r_tgt_ok  <= 32'(tgt_fid) < 32'(NUM_FUNCS);
        end
    end

    // Entries below the top; a push stores the old top with the push's timestamp.
    always_ff @(posedge i_clk) begin
        if (stk_wr) begin
            stk_mem[lvl_m1[SW-1:0]] <= {r_top_fid, r_ts};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stk_q <= stk_mem[lvl_m2[SW-1:0]];
        end
    end

    assign i_evt.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.func_id_out = r_out_fid;
    assign o_res.total_time  = r_out_total;
    assign o_res.updated     = r_out_upd;
    assign o_res.status      = r_out_status;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond stack depth");

    a_level_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_level != $past(r_level)) |-> $past(r_state == S_EXEC))
        else $error("stack level changed outside write-back");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !i_evt.ready)
        else $error("event taken during clearing pass");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.updated |-> (o_res.func_id_out == '0)
                                        && (o_res.total_time == '0))
        else $error("result fields not zero without update");

endmodule

`default_nettype wire
